// File: rtl/spa_pkg.sv
`default_nettype none
package spa_pkg;
   localparam int NUM_POOLS_DEF = 8;
   localparam int PAGE_BYTES_DEF = 4096;
   localparam int HEAP_PAGES_DEF = 16;
   localparam int GRANULE_BYTES_DEF = 4;
   localparam int SIZE_W = 13;
   localparam int CNT_W = 15;
   localparam int WASTE_W = 17;
   localparam int ADDR_W = 16;
   localparam int LINK_W = 15;
   localparam int LINK_DEPTH = 16384;
   localparam logic [LINK_W-1:0] NULL_LINK = 15'h4000;
   localparam logic [CNT_W-1:0] CNT_MAX = 15'h7fff;
   localparam logic [WASTE_W-1:0] WASTE_MAX = 17'h1ffff;
   localparam logic [2:0] SPARE_FIRST = 3'd3;
   localparam logic [2:0] ONCE_POOL = 3'd4;
   localparam logic [12:0] NAME_EXTRA = 13'd2;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_LEN   = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PICK,
      ST_DECIDE,
      ST_READ,
      ST_POP,
      ST_SP_FIRST,
      ST_SP_LOOP,
      ST_SP_END,
      ST_DONE,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

// File: rtl/spa_ram.sv
`default_nettype none
module spa_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/segregated_pool_allocator_core.sv
`default_nettype none
// Fixed-size pool allocator. Each item is a pool allocate (mode 0), a free (mode 1) or an
// allocate by length (mode 2) and returns one result item. A free or an unknown mode goes
// from the pick state straight to done and out. A carve from the bump region also passes
// the decide state, and a pop from a free list adds a registered link memory read (read,
// then pop). An allocate by length first scans for the best pool, one pool per cycle.
// When a new page is taken the leftover bytes are spread over the free lists one pool per
// cycle, each spread step writing one link entry when that pool's block still fits. The
// link memory has no reset; free lists only point at entries that were written. Items are
// taken one at a time, and the next item can be accepted as soon as a result is loaded
// into its register. A result stays in its register until taken while the next item is
// already being worked on; the following result waits until the register is free.
module segregated_pool_allocator_core
   import spa_pkg::*;
#(
   parameter int NUM_POOLS = spa_pkg::NUM_POOLS_DEF,
   parameter int PAGE_BYTES = spa_pkg::PAGE_BYTES_DEF,
   parameter int HEAP_PAGES = spa_pkg::HEAP_PAGES_DEF,
   parameter int GRANULE_BYTES = spa_pkg::GRANULE_BYTES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_mode,
   input  wire logic [2:0]                 req_pool,
   input  wire logic [spa_pkg::ADDR_W-1:0] req_address,
   input  wire logic [11:0]                req_length,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [spa_pkg::ADDR_W-1:0]      rsp_block_address,
   output logic                            rsp_success,
   output logic [2:0]                      rsp_chosen_pool,
   output logic [spa_pkg::CNT_W-1:0]       rsp_used_count,
   output logic [spa_pkg::CNT_W-1:0]       rsp_total_count,
   output logic [spa_pkg::WASTE_W-1:0]     rsp_waste_bytes,
   input  wire logic                       csr_write_enable,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [spa_pkg::SIZE_W-1:0] csr_write_data
);
   localparam int GSH = $clog2(GRANULE_BYTES);
   localparam int LIX_W = $clog2(LINK_DEPTH);
   localparam int PG_W = $clog2(HEAP_PAGES + 1);
   localparam int PSH = $clog2(PAGE_BYTES);
   localparam logic [2:0] LAST_POOL = 3'(NUM_POOLS - 1);
   localparam logic [17:0] PAGE_L = 18'(PAGE_BYTES);
   localparam logic [3:0] NP4 = 4'(NUM_POOLS);

   logic [SIZE_W-1:0] size_ff [8];
   logic [LINK_W-1:0] head_ff [8];
   logic [CNT_W-1:0] used_ff [8];
   logic [CNT_W-1:0] total_ff [8];
   logic [2:0] spill_ff;
   logic [ADDR_W-1:0] cptr_ff;
   logic [17:0] crem_ff;
   logic [PG_W-1:0] pages_ff;
   logic [WASTE_W-1:0] waste_ff;

   state_type state_ff, state_in;
   logic [1:0] mode_ff;
   logic [2:0] pool_ff, idx_ff;
   logic [ADDR_W-1:0] raddr_ff, saddr_ff, oaddr_ff;
   logic [11:0] len_ff;
   logic [13:0] best_ff;
   logic [17:0] ssize_ff;
   logic [12:0] small_ff;
   logic [3:0] idle_ff;
   logic four_ff, ok_ff;
   logic [3:0] scan_ff;

   logic wr_en;
   logic [LIX_W-1:0] wr_addr, rd_addr;
   logic [LINK_W-1:0] wr_data, rd_data;

   spa_ram #(.WIDTH(LINK_W), .DEPTH(LINK_DEPTH)) u_link (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
      return (c < CNT_MAX) ? c + 1'b1 : c;
   endfunction

   logic [12:0] psize;
   logic [12:0] isize;
   logic [17:0] tail_len;
   logic take_new, can_page, sp_hit;
   logic [12:0] need;
   logic [ADDR_W-1:0] page_addr;
   logic out_load;
   assign psize = size_ff[pool_ff];
   assign isize = size_ff[idx_ff];
   assign need = {1'b0, len_ff} + NAME_EXTRA;
   assign tail_len = PAGE_L - {5'd0, psize};
   assign can_page = ({5'd0, psize} <= PAGE_L) && (32'(pages_ff) < HEAP_PAGES);
   assign take_new = crem_ff >= tail_len;
   assign sp_hit = (isize != 0) && (ssize_ff >= {5'd0, isize})
      && (!four_ff || idx_ff != ONCE_POOL);
   assign page_addr = ADDR_W'(pages_ff) << PSH;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && req_ready) begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (mode_ff == MODE_LEN && scan_ff != NP4) state_in = ST_PICK;
            else if (mode_ff == MODE_NONE || mode_ff == MODE_FREE
                     || pool_ff > LAST_POOL) state_in = ST_DONE;
            else state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (head_ff[pool_ff] != NULL_LINK) state_in = ST_READ;
            else if (crem_ff >= {5'd0, psize}) state_in = ST_DONE;
            else if (!can_page) state_in = ST_DONE;
            else state_in = ST_SP_FIRST;
         end
         ST_READ: state_in = ST_POP;
         ST_POP: state_in = ST_DONE;
         ST_SP_FIRST: state_in = ST_SP_LOOP;
         ST_SP_LOOP: begin
            if (small_ff == 0 || ssize_ff < {5'd0, small_ff} || idle_ff >= NP4)
               state_in = ST_SP_END;
         end
         ST_SP_END: state_in = ST_DONE;
         ST_DONE: state_in = ST_OUT;
         ST_OUT: if (!rsp_valid || rsp_ready) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      wr_en = 1'b0;
      wr_addr = LIX_W'(saddr_ff >> GSH);
      wr_data = head_ff[idx_ff];
      rd_addr = LIX_W'(head_ff[pool_ff]);
      unique case (state_ff)
         ST_PICK: if (mode_ff == MODE_FREE && pool_ff <= LAST_POOL) begin
            wr_en = 1'b1;
            wr_addr = LIX_W'(raddr_ff >> GSH);
            wr_data = head_ff[pool_ff];
         end
         ST_SP_FIRST: begin
            wr_en = (size_ff[SPARE_FIRST] != 0)
               && (ssize_ff >= {5'd0, size_ff[SPARE_FIRST]});
            wr_data = head_ff[SPARE_FIRST];
         end
         ST_SP_LOOP: begin
            wr_en = !(small_ff == 0 || ssize_ff < {5'd0, small_ff} || idle_ff >= NP4)
               && sp_hit;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid <= 1'b0;
         size_ff[0] <= 13'd16; size_ff[1] <= 13'd32; size_ff[2] <= 13'd48;
         size_ff[3] <= 13'd64; size_ff[4] <= 13'd96; size_ff[5] <= 13'd128;
         size_ff[6] <= 13'd256; size_ff[7] <= 13'd512;
         for (int i = 0; i < 8; i++) begin
            head_ff[i] <= NULL_LINK;
            used_ff[i] <= '0;
            total_ff[i] <= '0;
         end
         spill_ff <= '0;
         cptr_ff <= '0;
         crem_ff <= '0;
         pages_ff <= '0;
         waste_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) size_ff[csr_index] <= csr_write_data;
         if (out_load) rsp_valid <= 1'b1;
         else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid && req_ready) begin
               mode_ff <= req_mode;
               pool_ff <= (req_mode == MODE_LEN || req_mode == MODE_NONE) ? 3'd0 : req_pool;
               raddr_ff <= req_address;
               len_ff <= req_length;
               best_ff <= 14'h3fff;
               scan_ff <= '0;
               ok_ff <= 1'b0;
               oaddr_ff <= '0;
            end
            ST_PICK: begin
               if (mode_ff == MODE_LEN && scan_ff != NP4) begin
                  if (size_ff[scan_ff[2:0]] >= need
                      && {1'b0, size_ff[scan_ff[2:0]]} < best_ff) begin
                     best_ff <= {1'b0, size_ff[scan_ff[2:0]]};
                     pool_ff <= scan_ff[2:0];
                  end
                  scan_ff <= scan_ff + 1'b1;
               end else if (mode_ff == MODE_FREE && pool_ff <= LAST_POOL) begin
                  head_ff[pool_ff] <= LINK_W'(raddr_ff >> GSH);
                  if (used_ff[pool_ff] != 0) used_ff[pool_ff] <= used_ff[pool_ff] - 1'b1;
                  ok_ff <= 1'b1;
               end
            end
            ST_DECIDE: begin
               if (head_ff[pool_ff] != NULL_LINK) begin
                  oaddr_ff <= ADDR_W'({head_ff[pool_ff][LIX_W-1:0], GSH'(0)});
               end else if (crem_ff >= {5'd0, psize}) begin
                  oaddr_ff <= cptr_ff;
                  ok_ff <= 1'b1;
                  cptr_ff <= cptr_ff + ADDR_W'(psize);
                  crem_ff <= crem_ff - {5'd0, psize};
                  total_ff[pool_ff] <= inc_sat(total_ff[pool_ff]);
                  used_ff[pool_ff] <= inc_sat(used_ff[pool_ff]);
               end else if (can_page) begin
                  ok_ff <= 1'b1;
                  oaddr_ff <= page_addr;
                  pages_ff <= pages_ff + 1'b1;
                  if (!take_new) begin
                     saddr_ff <= cptr_ff;
                     ssize_ff <= crem_ff;
                     cptr_ff <= page_addr + ADDR_W'(psize);
                     crem_ff <= tail_len;
                  end else begin
                     saddr_ff <= page_addr + ADDR_W'(psize);
                     ssize_ff <= tail_len;
                  end
                  idx_ff <= spill_ff;
                  spill_ff <= (spill_ff == LAST_POOL) ? 3'd0 : spill_ff + 1'b1;
                  idle_ff <= '0;
                  four_ff <= 1'b0;
                  small_ff <= '0;
                  scan_ff <= '0;
               end
            end
            ST_POP: begin
               ok_ff <= 1'b1;
               head_ff[pool_ff] <= rd_data;
               used_ff[pool_ff] <= inc_sat(used_ff[pool_ff]);
            end
            ST_SP_FIRST: begin
               // smallest nonzero size, fixed while spreading
               begin
                  logic [12:0] m;
                  m = '0;
                  for (int i = 0; i < NUM_POOLS; i++) begin
                     if (size_ff[i] != 0 && (m == 0 || size_ff[i] < m)) m = size_ff[i];
                  end
                  small_ff <= m;
               end
               if (wr_en) begin
                  head_ff[SPARE_FIRST] <= LINK_W'(saddr_ff >> GSH);
                  total_ff[SPARE_FIRST] <= inc_sat(total_ff[SPARE_FIRST]);
                  ssize_ff <= ssize_ff - {5'd0, size_ff[SPARE_FIRST]};
                  saddr_ff <= saddr_ff + ADDR_W'(size_ff[SPARE_FIRST]);
               end
            end
            ST_SP_LOOP: if (state_in == ST_SP_LOOP) begin
               if (sp_hit) begin
                  head_ff[idx_ff] <= LINK_W'(saddr_ff >> GSH);
                  total_ff[idx_ff] <= inc_sat(total_ff[idx_ff]);
                  ssize_ff <= ssize_ff - {5'd0, isize};
                  saddr_ff <= saddr_ff + ADDR_W'(isize);
                  idle_ff <= '0;
               end else begin
                  idle_ff <= idle_ff + 1'b1;
               end
               if (idx_ff == ONCE_POOL) four_ff <= 1'b1;
               idx_ff <= (idx_ff == LAST_POOL) ? 3'd0 : idx_ff + 1'b1;
            end
            ST_SP_END: begin
               waste_ff <= ({1'b0, waste_ff} + 18'(ssize_ff) > {1'b0, WASTE_MAX})
                  ? WASTE_MAX : waste_ff + WASTE_W'(ssize_ff);
               total_ff[pool_ff] <= inc_sat(total_ff[pool_ff]);
               used_ff[pool_ff] <= inc_sat(used_ff[pool_ff]);
            end
            ST_OUT: if (!rsp_valid || rsp_ready) begin
               rsp_block_address <= ok_ff ? oaddr_ff : '0;
               rsp_success <= ok_ff;
               rsp_chosen_pool <= pool_ff;
               rsp_used_count <= (pool_ff > LAST_POOL) ? '0 : used_ff[pool_ff];
               rsp_total_count <= (pool_ff > LAST_POOL) ? '0 : total_ff[pool_ff];
               rsp_waste_bytes <= waste_ff;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: tb/sv/spa_scoreboard.sv
`default_nettype none
module spa_scoreboard
   import spa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic [2:0]         req_pool,
   input  wire logic [ADDR_W-1:0]  req_address,
   input  wire logic [11:0]        req_length,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [ADDR_W-1:0]  rsp_block_address,
   input  wire logic               rsp_success,
   input  wire logic [2:0]         rsp_chosen_pool,
   input  wire logic [CNT_W-1:0]   rsp_used_count,
   input  wire logic [CNT_W-1:0]   rsp_total_count,
   input  wire logic [WASTE_W-1:0] rsp_waste_bytes,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [SIZE_W-1:0]  csr_write_data,
   input  wire logic               drain,
   output int                      fail_count
);
   typedef struct packed {
      logic [ADDR_W-1:0]  block_address;
      logic               success;
      logic [2:0]         chosen_pool;
      logic [CNT_W-1:0]   used_count;
      logic [CNT_W-1:0]   total_count;
      logic [WASTE_W-1:0] waste_bytes;
   } alloc_result_type;

   localparam int POOLS = NUM_POOLS_DEF;
   localparam int PAGE = PAGE_BYTES_DEF;
   localparam int PAGES = HEAP_PAGES_DEF;
   localparam int GRAN = GRANULE_BYTES_DEF;

   logic [LINK_W-1:0] link_mem [LINK_DEPTH];
   int block_size [8];
   int head [8];
   int used [8];
   int total [8];
   int spill_start, carve_ptr, carve_left, pages_taken, waste;
   alloc_result_type pending_results [$];
   bit drained;

   function automatic int sat_inc(int c);
      return (c < int'(CNT_MAX)) ? c + 1 : c;
   endfunction

   function automatic void link_push(int p, int a);
      int i;
      i = ((a & 16'hffff) / GRAN) % LINK_DEPTH;
      link_mem[i] = head[p][LINK_W-1:0];
      head[p] = i;
   endfunction

   function automatic void spread_tail(int a, int sz);
      int idx, smallest, idle, s;
      bit did_once;
      idx = spill_start % POOLS;
      spill_start = (idx + 1) % POOLS;
      smallest = 0;
      idle = 0;
      did_once = 0;
      for (int i = 0; i < POOLS; i++)
         if (block_size[i] != 0 && (smallest == 0 || block_size[i] < smallest))
            smallest = block_size[i];
      if (block_size[SPARE_FIRST] != 0 && sz >= block_size[SPARE_FIRST]) begin
         link_push(SPARE_FIRST, a);
         total[SPARE_FIRST] = sat_inc(total[SPARE_FIRST]);
         sz -= block_size[SPARE_FIRST];
         a += block_size[SPARE_FIRST];
      end
      while (smallest != 0 && sz >= smallest && idle < POOLS) begin
         s = block_size[idx];
         if (s != 0 && sz >= s && (!did_once || idx != ONCE_POOL)) begin
            link_push(idx, a);
            total[idx] = sat_inc(total[idx]);
            sz -= s;
            a += s;
            idle = 0;
         end else begin
            idle++;
         end
         if (idx == ONCE_POOL) did_once = 1;
         idx = (idx + 1) % POOLS;
      end
      waste += sz;
      if (waste > int'(WASTE_MAX)) waste = WASTE_MAX;
   endfunction

   function automatic bit take_block(int p, output int a);
      int sz, i, page, tail_a, tail_n;
      sz = block_size[p];
      a = 0;
      if (head[p] != int'(NULL_LINK)) begin
         i = head[p] % LINK_DEPTH;
         a = i * GRAN;
         head[p] = link_mem[i];
      end else if (carve_left >= sz) begin
         a = carve_ptr;
         carve_left -= sz;
         carve_ptr += sz;
         total[p] = sat_inc(total[p]);
      end else begin
         if (sz > PAGE || pages_taken >= PAGES) return 0;
         page = pages_taken * PAGE;
         pages_taken++;
         a = page;
         tail_a = page + sz;
         tail_n = PAGE - sz;
         if (carve_left < tail_n) begin
            tail_a = carve_ptr;
            tail_n = carve_left;
            carve_ptr = page + sz;
            carve_left = PAGE - sz;
         end
         spread_tail(tail_a, tail_n);
         total[p] = sat_inc(total[p]);
      end
      used[p] = sat_inc(used[p]);
      return 1;
   endfunction

   function automatic alloc_result_type predict_item(int mode, int pool, int address,
                                                     int length);
      alloc_result_type r;
      int a, chosen, need, best;
      bit ok, valid;
      a = 0;
      ok = 0;
      chosen = pool;
      valid = pool < POOLS;
      case (mode)
         MODE_ALLOC: begin
            if (valid && take_block(pool, a)) ok = 1;
         end
         MODE_FREE: begin
            if (valid) begin
               link_push(pool, address);
               if (used[pool] > 0) used[pool]--;
               ok = 1;
            end
         end
         MODE_LEN: begin
            need = length + NAME_EXTRA;
            best = 16'hffff;
            chosen = 0;
            for (int i = 0; i < POOLS; i++)
               if (block_size[i] >= need && block_size[i] < best) begin
                  best = block_size[i];
                  chosen = i;
               end
            valid = 1;
            if (take_block(chosen, a)) ok = 1;
         end
         default: begin
            chosen = 0;
            valid = 1;
         end
      endcase
      if (!ok) a = 0;
      r.block_address = a[ADDR_W-1:0];
      r.success = ok;
      r.chosen_pool = chosen[2:0];
      r.used_count = valid ? used[chosen][CNT_W-1:0] : '0;
      r.total_count = valid ? total[chosen][CNT_W-1:0] : '0;
      r.waste_bytes = waste[WASTE_W-1:0];
      return r;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            block_size[i] = 16 << 0;
            head[i] = NULL_LINK;
            used[i] = 0;
            total[i] = 0;
         end
         block_size[0] = 16;  block_size[1] = 32;  block_size[2] = 48;
         block_size[3] = 64;  block_size[4] = 96;  block_size[5] = 128;
         block_size[6] = 256; block_size[7] = 512;
         spill_start = 0;
         carve_ptr = 0;
         carve_left = 0;
         pages_taken = 0;
         waste = 0;
         pending_results.delete();
         drained = 0;
      end else begin
         if (csr_write_enable) block_size[csr_index] = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report("unexpected item", rsp_block_address, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_block_address !== want.block_address)
                  report("block_address", rsp_block_address, want.block_address);
               if (rsp_success !== want.success)
                  report("success", rsp_success, want.success);
               if (rsp_chosen_pool !== want.chosen_pool)
                  report("chosen_pool", rsp_chosen_pool, want.chosen_pool);
               if (rsp_used_count !== want.used_count)
                  report("used_count", rsp_used_count, want.used_count);
               if (rsp_total_count !== want.total_count)
                  report("total_count", rsp_total_count, want.total_count);
               if (rsp_waste_bytes !== want.waste_bytes)
                  report("waste_bytes", rsp_waste_bytes, want.waste_bytes);
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(predict_item(req_mode, req_pool, req_address,
                                                   req_length));
         if (drain && !drained) begin
            drained = 1;
            if (pending_results.size() != 0)
               report("missing items", 0, pending_results.size());
         end
      end
   end
endmodule
`default_nettype wire

// File: tb/sv/segregated_pool_allocator_core_tb.sv
`default_nettype none
module segregated_pool_allocator_core_tb;
   import spa_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_ready;
   logic [1:0]          req_mode = MODE_ALLOC;
   logic [2:0]          req_pool = 0;
   logic [ADDR_W-1:0]   req_address = 0;
   logic [11:0]         req_length = 0;
   logic                rsp_valid;
   logic                rsp_ready = 0;
   logic [ADDR_W-1:0]   rsp_block_address;
   logic                rsp_success;
   logic [2:0]          rsp_chosen_pool;
   logic [CNT_W-1:0]    rsp_used_count;
   logic [CNT_W-1:0]    rsp_total_count;
   logic [WASTE_W-1:0]  rsp_waste_bytes;
   logic                csr_write_enable = 0;
   logic [2:0]          csr_index = 0;
   logic [SIZE_W-1:0]   csr_write_data = 0;
   logic                drain = 0;
   int                  fail_count;

   int  cycles = 0;
   int  sent = 0;
   int  received = 0;
   bit  calm = 0;
   int  hold_ask = 0;
   int  cfg [8];
   logic [1:0] sent_modes [$];
   logic [18:0] live_blocks [$];

   always #10 clock = ~clock;

   segregated_pool_allocator_core i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_pool, .req_address,
      .req_length, .rsp_valid, .rsp_ready, .rsp_block_address, .rsp_success,
      .rsp_chosen_pool, .rsp_used_count, .rsp_total_count, .rsp_waste_bytes,
      .csr_write_enable, .csr_index, .csr_write_data
   );

   spa_scoreboard i_scoreboard (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_pool, .req_address,
      .req_length, .rsp_valid, .rsp_ready, .rsp_block_address, .rsp_success,
      .rsp_chosen_pool, .rsp_used_count, .rsp_total_count, .rsp_waste_bytes,
      .csr_write_enable, .csr_index, .csr_write_data, .drain, .fail_count
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // track live blocks so frees can return them
   always @(posedge clock) begin
      logic [1:0] m;
      if (!reset && rsp_valid && rsp_ready) begin
         received <= received + 1;
         if (sent_modes.size() != 0) begin
            m = sent_modes.pop_front();
            if (m != MODE_FREE && rsp_success)
               live_blocks.push_back({rsp_chosen_pool, rsp_block_address});
         end
      end
   end

   initial begin : receiver
      int w, seen;
      seen = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         w = calm ? 0 : $urandom_range(0, 12);
         if (hold_ask != seen) begin
            seen = hold_ask;
            w = 400;
         end
         if (w > 0) begin
            rsp_ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_item(input logic [1:0] mode, input logic [2:0] pool,
                            input logic [15:0] address, input logic [11:0] length);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_pool <= pool;
      req_address <= address;
      req_length <= length;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_modes.push_back(mode);
      sent++;
   endtask

   task automatic random_item();
      int pick, k;
      logic [18:0] blk;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_item(MODE_ALLOC, 3'($urandom_range(0, 7)), 16'($urandom), 12'($urandom));
      end else if (pick < 68 && live_blocks.size() != 0) begin
         k = $urandom_range(0, live_blocks.size() - 1);
         blk = live_blocks[k];
         live_blocks.delete(k);
         send_item(MODE_FREE, blk[18:16], blk[15:0], 12'($urandom));
      end else if (pick < 73) begin
         send_item(MODE_FREE, 3'($urandom_range(0, 7)), 16'($urandom), 12'($urandom));
      end else if (pick < 88) begin
         send_item(MODE_LEN, 3'($urandom), 16'($urandom), 12'($urandom_range(0, 600)));
      end else if (pick < 95) begin
         send_item(MODE_LEN, 3'($urandom), 16'($urandom), 12'($urandom));
      end else begin
         send_item(MODE_NONE, 3'($urandom), 16'($urandom), 12'($urandom));
      end
   endtask

   task automatic program_sizes();
      req_valid <= 0;
      while (received != sent) @(posedge clock);
      repeat (4) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_write_enable <= 1;
         csr_index <= 3'(i);
         csr_write_data <= SIZE_W'(cfg[i]);
         @(posedge clock);
      end
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every pool, length extremes, odd frees, unknown mode
      for (int p = 0; p < 8; p++) send_item(MODE_ALLOC, 3'(p), 16'h0000, 12'h000);
      send_item(MODE_LEN, 3'd0, 16'hffff, 12'd0);
      send_item(MODE_LEN, 3'd7, 16'h0000, 12'd510);
      send_item(MODE_LEN, 3'd2, 16'h0000, 12'd4094);
      send_item(MODE_LEN, 3'd5, 16'h0000, 12'hfff);
      send_item(MODE_NONE, 3'd7, 16'hffff, 12'hfff);
      send_item(MODE_FREE, 3'd7, 16'hffff, 12'hfff);
      send_item(MODE_ALLOC, 3'd7, 16'h0000, 12'h000);
      send_item(MODE_FREE, 3'd0, 16'h0000, 12'h000);
      send_item(MODE_FREE, 3'd0, 16'h0002, 12'h000);
      send_item(MODE_ALLOC, 3'd0, 16'h0000, 12'h000);
      send_item(MODE_ALLOC, 3'd0, 16'h0000, 12'h000);
      send_item(MODE_FREE, 3'd4, 16'h8001, 12'h000);
      send_item(MODE_ALLOC, 3'd4, 16'h0000, 12'h000);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: for (int i = 0; i < 8; i++) cfg[i] = 4 * $urandom_range(1, 160);
            2: for (int i = 0; i < 8; i++) cfg[i] = 4;
            3: for (int i = 0; i < 8; i++) cfg[i] = (i % 2) ? 4096 : 4 * $urandom_range(1, 1024);
            4: for (int i = 0; i < 8; i++) cfg[i] = 4 * $urandom_range(1, 64);
            default: ;
         endcase
         if (ph > 0) program_sizes();
         calm = (ph == 2);
         for (int n = 0; n < 105; n++) begin
            if (ph == 1 && n == 20) hold_ask++;
            random_item();
         end
      end

      req_valid <= 0;
      while (received != sent) @(posedge clock);
      repeat (20) @(posedge clock);
      drain <= 1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
